### rtl/core/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared constants, register indexes and types for the LED pattern generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpg_pkg;

  // Width of the time registers that take effect (the mask keeps all 8 bits of the value).
  localparam int unsigned TimeBits = 8;
  localparam int unsigned WaitW    = TimeBits + 4;
  localparam int unsigned StepW    = 16;
  localparam int unsigned DoneW    = 8;
  localparam int unsigned CfgW     = 8;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [15:0] TimeMask = 16'((32'd1 << TimeBits) - 32'd1);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgStyle  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMorse  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOn     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOff    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPause  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRepeat = 3'd5;

  // Pattern style codes
  localparam logic [3:0] StyleBlink    = 4'd0;
  localparam logic [3:0] StyleMorseMin = 4'd1;
  localparam logic [3:0] StyleMorseMax = 4'd8;
  localparam logic [3:0] StyleFade     = 4'd9;

  // Fade step counter layout
  localparam logic [StepW-1:0] FadeDir     = 16'h8000;
  localparam logic [StepW-1:0] FadeLvlMask = 16'h7F00;
  localparam logic [StepW-1:0] FadeLvlTop  = 16'h0F00;
  localparam logic [StepW-1:0] FadeSubStep = 16'h0010;
  localparam logic [StepW-1:0] FadeKeep    = 16'hFFFC;

  typedef struct packed {
    logic [3:0]      pattern_style;
    logic [CfgW-1:0] morse_code;
    logic [CfgW-1:0] on_time;
    logic [CfgW-1:0] off_time;
    logic [CfgW-1:0] pause_time;
    logic [CfgW-1:0] repeat_count;
  } cfg_t;

  // Time register value as a wait count, masked to TimeBits.
  function automatic logic [WaitW-1:0] time_ext(input logic [CfgW-1:0] v);
    logic [15:0] w;
    w = {8'd0, v} & TimeMask;
    return WaitW'(w);
  endfunction

endpackage

`default_nettype wire

### rtl/core/lpg_cfg.sv
// ----------------------------------------------------------------------------
// lpg_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpg_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [lpg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [lpg_pkg::CfgW-1:0]    cfg_wdata_i,
  output lpg_pkg::cfg_t                    cfg_o
);
  import lpg_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStyle:  cfg_d.pattern_style = cfg_wdata_i[3:0];
        CfgMorse:  cfg_d.morse_code    = cfg_wdata_i;
        CfgOn:     cfg_d.on_time       = cfg_wdata_i;
        CfgOff:    cfg_d.off_time      = cfg_wdata_i;
        CfgPause:  cfg_d.pause_time    = cfg_wdata_i;
        CfgRepeat: cfg_d.repeat_count  = cfg_wdata_i;
        default:   cfg_d = cfg_q;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/core/lpg_engine.sv
// ----------------------------------------------------------------------------
// lpg_engine
// Pattern state and one-tick update; LED level and done count are the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpg_engine (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire lpg_pkg::cfg_t             cfg_i,
  input  wire logic                      tick_i,   // apply one tick
  input  wire logic                      clear_i,  // clear done count first
  output logic                           led_o,
  output logic [lpg_pkg::DoneW-1:0]      done_o
);
  import lpg_pkg::*;

  logic [WaitW-1:0] wait_q, wait_d;
  logic [StepW-1:0] step_q, step_d;
  logic [DoneW-1:0] done_q, done_d;
  logic             led_q,  led_d;

  logic [StepW-1:0] step_inc;
  logic [StepW-1:0] rep2;
  logic [14:0]      midx;
  logic [14:0]      mbit;
  logic             mshort;
  logic [StepW-1:0] fc;
  logic [1:0]       plane;
  logic [7:0]       flvl;
  logic [WaitW-1:0] wait_dec;

  always_comb begin
    done_d   = clear_i ? '0 : done_q;
    wait_dec = (wait_q != '0) ? wait_q - WaitW'(1) : '0;
    wait_d   = wait_dec;
    step_d   = step_q;
    led_d    = led_q;

    step_inc = step_q + StepW'(1);
    rep2     = {7'd0, cfg_i.repeat_count, 1'b0};
    midx     = step_q[StepW-1:1];
    mbit     = midx - 15'd3;
    mshort   = (midx >= 15'd3) && (mbit < 15'd8) && cfg_i.morse_code[mbit[2:0]];
    fc       = step_q;
    plane    = '0;
    flvl     = '0;

    if (wait_dec == '0) begin
      if (cfg_i.pattern_style == StyleBlink) begin
        step_d = step_inc;
        if ((cfg_i.repeat_count != '0) && (step_inc == rep2)) begin
          led_d  = 1'b0;
          wait_d = time_ext(cfg_i.pause_time);
          step_d = '0;
          done_d = done_d + DoneW'(1);
        end else if ((cfg_i.repeat_count != '0) && step_inc[0] &&
                     (time_ext(cfg_i.on_time) != '0)) begin
          led_d  = 1'b1;
          wait_d = time_ext(cfg_i.on_time);
        end else begin
          led_d  = 1'b0;
          wait_d = time_ext(cfg_i.off_time);
        end
      end else if (cfg_i.pattern_style inside {[StyleMorseMin:StyleMorseMax]}) begin
        step_d = step_inc;
        if ((midx >= 15'd3) && (mbit >= {11'd0, cfg_i.pattern_style})) begin
          // pattern complete: pause
          led_d  = 1'b0;
          wait_d = time_ext(cfg_i.pause_time);
          step_d = '0;
          done_d = done_d + DoneW'(1);
        end else if (!step_inc[0]) begin
          led_d  = 1'b0;
          wait_d = time_ext(cfg_i.off_time);
        end else if (!mshort) begin
          led_d  = 1'b1;
          wait_d = time_ext(cfg_i.on_time) << 4;
        end else begin
          led_d  = 1'b1;
          wait_d = time_ext(cfg_i.on_time);
        end
      end else if (cfg_i.pattern_style == StyleFade) begin
        if ((step_q & FadeDir) == '0) begin
          fc = step_q + FadeSubStep;
          if ((fc & FadeLvlMask) > FadeLvlTop) begin
            fc     = fc | FadeDir;
            done_d = done_d + DoneW'(1);
          end
        end else begin
          fc = (step_q - FadeSubStep) | FadeDir;
          if ((fc & FadeLvlMask) == '0) begin
            fc = fc & ~FadeDir;
          end
        end
        plane  = fc[1:0] + 2'd1;
        fc     = (fc & FadeKeep) | {14'd0, plane};
        flvl   = fc[15:8];
        step_d = fc;
        wait_d = WaitW'(1) << plane;
        led_d  = flvl[plane];
      end
      // unused styles: hold LED and step; the done count changes only by a clear
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q <= '0;
      step_q <= '0;
      done_q <= '0;
      led_q  <= 1'b0;
    end else if (tick_i) begin
      wait_q <= wait_d;
      step_q <= step_d;
      done_q <= done_d;
      led_q  <= led_d;
    end
  end

  assign led_o  = led_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

### rtl/core/led_pattern_generator_top.sv
// ----------------------------------------------------------------------------
// led_pattern_generator_top
// One-channel LED pattern engine (blink, morse, 4-bit fade) driven by ticks.
// ----------------------------------------------------------------------------
// Each input transaction is one time tick and produces exactly one output
// transaction carrying the LED level after the tick and the count of
// completed patterns (fade peaks in fade mode). The block sustains one
// transaction per clock while the result channel is not stalled: a tick is
// captured in an input register, then the engine applies it in one pass of
// logic once the result register is free, and the new state itself is the
// result register, so the result is held there until it is taken.
// The pattern state advances only when the result register is free (empty
// or being taken), which is what limits throughput under output
// backpressure. Registers are written through the configuration port, one
// per cycle, and must only be changed while no transaction is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module led_pattern_generator_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write port
  input  wire logic                        cfg_we_i,
  input  wire logic [lpg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [lpg_pkg::CfgW-1:0]    cfg_wdata_i,
  // tick input channel
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        clear_count_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             led_on_o,
  output logic [lpg_pkg::DoneW-1:0]        patterns_done_o
);
  import lpg_pkg::*;

  cfg_t cfg;

  // Input stage
  logic in_vld_q;
  logic clear_q;

  // Result stage valid; the payload lives in the engine state
  logic out_vld_q;

  logic res_free;  // result register can take a new tick this cycle
  logic advance;   // input stage moves into the engine

  assign res_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && res_free;
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (res_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      clear_q <= clear_count_i;
    end
  end

  lpg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lpg_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .tick_i  (advance),
    .clear_i (clear_q),
    .led_o   (led_on_o),
    .done_o  (patterns_done_o)
  );

  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LED pattern generator: directed ticks, then
// random register settings with random ticks. The predicted LED level and
// pattern count of every tick are compared with the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lpg_pkg::*;

  // Run limits. The worst case is roughly 1000 ticks, each behind a long
  // input gap and a long output stall, so the cycle limit is far above that.
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned RandomTicks  = 950;
  localparam int unsigned WrapTicks    = 520;
  localparam int unsigned ClearPct     = 3;
  localparam logic [3:0]  StyleTop     = 4'hF;

  // LED level and pattern count after one tick
  typedef struct packed {
    logic             led;
    logic [DoneW-1:0] done;
  } led_state_t;

  // Scoreboard: carries its own copy of the pattern engine and the registers,
  // steps it once per accepted tick and checks results in order.
  class led_state_scoreboard;
    logic [3:0]       style;
    logic [CfgW-1:0]  code;
    logic [CfgW-1:0]  on_t;
    logic [CfgW-1:0]  off_t;
    logic [CfgW-1:0]  pause_t;
    logic [CfgW-1:0]  rep;
    logic [WaitW-1:0] wait_cnt;
    logic [StepW-1:0] step_cnt;
    logic [DoneW-1:0] done_cnt;
    logic             led;
    led_state_t       due_q[$];
    int unsigned      errors = 0;

    function void clear_all();
      style    = StyleBlink;
      code     = '0;
      on_t     = '0;
      off_t    = '0;
      pause_t  = '0;
      rep      = '0;
      wait_cnt = '0;
      step_cnt = '0;
      done_cnt = '0;
      led      = 1'b0;
    endfunction

    function void set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
      case (idx)
        CfgStyle:  style   = val[3:0];
        CfgMorse:  code    = val;
        CfgOn:     on_t    = val;
        CfgOff:    off_t   = val;
        CfgPause:  pause_t = val;
        CfgRepeat: rep     = val;
        default: ;
      endcase
    endfunction

    // time register as a wait count
    function logic [WaitW-1:0] ticks(input logic [CfgW-1:0] v);
      return WaitW'(v) & WaitW'(TimeMask);
    endfunction

    function void load(input logic level, input logic [WaitW-1:0] w);
      led      = level;
      wait_cnt = w;
    endfunction

    function void end_pattern();
      load(1'b0, ticks(pause_t));
      step_cnt = '0;
      done_cnt++;
    endfunction

    function void blink_action();
      step_cnt++;
      if (rep != 0 && step_cnt == {7'd0, rep, 1'b0}) begin
        end_pattern();
      end else if (rep != 0 && step_cnt[0] && ticks(on_t) != 0) begin
        load(1'b1, ticks(on_t));
      end else begin
        load(1'b0, ticks(off_t));
      end
    endfunction

    function void morse_action();
      int unsigned bit_idx;
      logic        is_long;
      bit_idx = step_cnt >> 1;
      is_long = 1'b1;
      step_cnt++;
      // first three symbols are long, then the code bits, LSB first
      if (bit_idx >= 3) begin
        bit_idx -= 3;
        if (bit_idx >= style) begin
          end_pattern();
          return;
        end
        if (bit_idx < 8 && code[bit_idx]) is_long = 1'b0;
      end
      if (!step_cnt[0]) begin
        load(1'b0, ticks(off_t));
      end else if (is_long) begin
        load(1'b1, ticks(on_t) << 4);
      end else begin
        load(1'b1, ticks(on_t));
      end
    endfunction

    function void fade_action();
      logic [StepW-1:0] c;
      logic [1:0]       plane;
      c = step_cnt;
      if ((c & FadeDir) == '0) begin
        c = c + FadeSubStep;
        if ((c & FadeLvlMask) > FadeLvlTop) begin
          c = c | FadeDir;
          done_cnt++;
        end
      end else begin
        c = (c - FadeSubStep) | FadeDir;
        if ((c & FadeLvlMask) == '0) c = c & ~FadeDir;
      end
      plane    = c[1:0] + 2'd1;
      c        = (c & FadeKeep) | StepW'(plane);
      step_cnt = c;
      load(c[8 + plane], WaitW'(1) << plane);
    endfunction

    function void note_tick(input logic clear);
      led_state_t s;
      if (clear) done_cnt = '0;
      if (wait_cnt != 0) wait_cnt--;
      if (wait_cnt == 0) begin
        if (style == StyleBlink) begin
          blink_action();
        end else if (style >= StyleMorseMin && style <= StyleMorseMax) begin
          morse_action();
        end else if (style == StyleFade) begin
          fade_action();
        end
      end
      s.led  = led;
      s.done = done_cnt;
      due_q.push_back(s);
    endfunction

    function void check_result(input logic led_o, input logic [DoneW-1:0] done_o);
      led_state_t s;
      if (due_q.size() == 0) begin
        $error("result without an outstanding tick: led_on=%0d patterns_done=%0d",
               led_o, done_o);
        errors++;
        return;
      end
      s = due_q.pop_front();
      if (led_o !== s.led) begin
        $error("led_on: expected %0d, actual %0d", s.led, led_o);
        errors++;
      end
      if (done_o !== s.done) begin
        $error("patterns_done: expected %0d, actual %0d", s.done, done_o);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return due_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               clear_count_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               led_on_o;
  logic [DoneW-1:0]   patterns_done_o;

  led_state_scoreboard led_sb;
  int unsigned         cycle_cnt = 0;

  led_pattern_generator_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .clear_count_i   (clear_count_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .led_on_o        (led_on_o),
    .patterns_done_o (patterns_done_o)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop in case the block hangs or drops results.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Both channels are observed in one process at the rising edge, so the
  // tick is always recorded before any result that could depend on it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) led_sb.note_tick(clear_count_i);
      if (out_valid_o && out_ready_i) led_sb.check_result(led_on_o, patterns_done_o);
    end
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // Time register: usually tiny so patterns turn over quickly.
  function automatic logic [CfgW-1:0] pick_time();
    int unsigned r;
    r = $urandom_range(9, 0);
    if (r == 0) return CfgW'($urandom);
    if (r == 1) return '1;
    return CfgW'($urandom_range(3, 0));
  endfunction

  function automatic logic [CfgW-1:0] pick_repeat();
    if ($urandom_range(9, 0) == 0) return CfgW'($urandom);
    return CfgW'($urandom_range(4, 0));
  endfunction

  // Result side backpressure: short stalls, some long ones, and stretches
  // where ready just stays high.
  initial begin : result_ready_driver
    int unsigned stall;
    forever begin
      out_ready_i = 1'b1;
      if ($urandom_range(7, 0) == 0) begin
        repeat ($urandom_range(120, 30)) @(negedge clk_i);
      end else begin
        repeat ($urandom_range(6, 1)) @(negedge clk_i);
        stall = pick_gap();
        if (stall != 0) begin
          out_ready_i = 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
    end
  end

  // Register write, only called with nothing in flight. Starts and ends on
  // a falling edge.
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    led_sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // Block until every predicted result has come back, then let the pipe settle.
  task automatic wait_idle();
    while (led_sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [3:0] sty, input logic [CfgW-1:0] cod,
                              input logic [CfgW-1:0] ont, input logic [CfgW-1:0] offt,
                              input logic [CfgW-1:0] pst, input logic [CfgW-1:0] rpt);
    wait_idle();
    cfg_write(CfgStyle, CfgW'(sty));
    cfg_write(CfgMorse, cod);
    cfg_write(CfgOn, ont);
    cfg_write(CfgOff, offt);
    cfg_write(CfgPause, pst);
    cfg_write(CfgRepeat, rpt);
  endtask

  // One tick transaction. Entered on a falling edge, returns on the falling
  // edge after acceptance; valid stays up when the next tick has no gap.
  task automatic send_tick(input logic clr, input int unsigned gap);
    if (gap != 0) begin
      in_valid_i    = 1'b0;
      clear_count_i = 1'($urandom);  // junk while idle
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    clear_count_i = clr;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic run_ticks(input int unsigned n, input int unsigned clear_pct,
                           input bit steady);
    int unsigned k;
    int unsigned gap;
    logic        clr;
    for (k = 0; k < n; k++) begin
      gap = steady ? 0 : pick_gap();
      clr = ($urandom_range(99, 0) < clear_pct);
      send_tick(clr, gap);
    end
    in_valid_i = 1'b0;
  endtask

  initial begin : stimulus
    logic [3:0]      sty;
    logic [CfgW-1:0] cod;
    logic [CfgW-1:0] ont;
    logic [CfgW-1:0] offt;
    logic [CfgW-1:0] pst;
    logic [CfgW-1:0] rpt;
    int unsigned     kind;
    int unsigned     n;
    int unsigned     sent;

    led_sb = new;
    led_sb.clear_all();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgStyle;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    clear_count_i = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // -- directed ------------------------------------------------------------
    // reset registers: blink with zero repeat keeps the LED dark
    send_tick(1'b1, 0);
    send_tick(1'b0, 0);
    send_tick(1'b0, 2);
    in_valid_i = 1'b0;
    // zero on time: odd steps turn into off steps
    program_regs(StyleBlink, 8'h00, 8'd0, 8'd1, 8'd0, 8'd2);
    run_ticks(5, 0, 1'b1);
    // plain single-pulse blink with a pause
    program_regs(StyleBlink, 8'h00, 8'd1, 8'd1, 8'd2, 8'd1);
    run_ticks(5, 0, 1'b1);
    // morse, all waits zero so every tick is an action
    program_regs(StyleMorseMax, 8'h5A, 8'd0, 8'd0, 8'd0, 8'd0);
    run_ticks(5, 0, 1'b1);
    // fade, with count clears mixed in
    program_regs(StyleFade, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0);
    run_ticks(4, 50, 1'b1);
    // unused style with every register bit set: LED, step and pattern count must hold
    program_regs(StyleTop, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_ticks(3, 0, 1'b0);

    // -- random --------------------------------------------------------------
    // fastest blink with no clears, long enough to wrap the pattern count
    program_regs(StyleBlink, CfgW'($urandom), 8'd0, 8'd0, 8'd0, 8'd1);
    run_ticks(WrapTicks, 0, 1'b0);
    sent = WrapTicks;

    // random settings; state carries over, so each switch also lands
    // mid-pattern in whatever the previous style left behind
    while (sent < RandomTicks) begin
      kind = $urandom_range(19, 0);
      cod  = CfgW'($urandom);
      ont  = pick_time();
      offt = pick_time();
      pst  = pick_time();
      rpt  = pick_repeat();
      if (kind < 6) begin
        sty = StyleBlink;
      end else if (kind < 13) begin
        sty = 4'($urandom_range(StyleMorseMax, StyleMorseMin));
      end else if (kind < 17) begin
        sty = StyleFade;
      end else if (kind == 17) begin
        sty = 4'($urandom_range(StyleTop, StyleFade + 4'd1));
      end else begin
        // full-range everything
        sty  = 4'($urandom);
        ont  = CfgW'($urandom);
        offt = CfgW'($urandom);
        pst  = CfgW'($urandom);
        rpt  = CfgW'($urandom);
      end
      n = $urandom_range(80, 30);
      program_regs(sty, cod, ont, offt, pst, rpt);
      run_ticks(n, ClearPct, $urandom_range(3, 0) == 0);
      sent += n;
    end

    // -- wrap up -------------------------------------------------------------
    wait_idle();
    if (led_sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
